[rtl/core/pdsr_pkg.sv]
package pdsr_pkg;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_LEVEL,
        ST_EMIT,
        ST_ADV
    } pdsr_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;     // latch a render request and read its phase
        logic load_phase;  // store the phase of a load request
        logic div_start;   // launch the divider
        logic level_ld;    // latch level and neighbour mask
        logic emit;        // push one write into the output register
        logic step;        // move to the next neighbour slot
        logic advance;     // write back the advanced phase
    } pdsr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic idx_ok;      // incoming dot index is in range
        logic div_done;    // quotient ready
        logic pix_on;      // current slot lies on the display
        logic slot_last;   // current slot is the final one
        logic out_free;    // output register can take a write
    } pdsr_status_t;

    localparam int unsigned SLOTS    = 5;
    localparam int unsigned STEPS_RST = 16;

    // slot order: centre, below, above, right, left
    localparam logic [2:0] SLOT_CENTRE = 3'd0;
    localparam logic [2:0] SLOT_DOWN   = 3'd1;
    localparam logic [2:0] SLOT_UP     = 3'd2;
    localparam logic [2:0] SLOT_RIGHT  = 3'd3;
    localparam logic [2:0] SLOT_LEFT   = 3'd4;

    localparam logic [7:0] GAMMA_LUT [256] = '{
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd1,
        8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
        8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
        8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
        8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,
        8'd5,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
        8'd7,   8'd8,   8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd10,
        8'd10,  8'd10,  8'd11,  8'd11,  8'd11,  8'd12,  8'd12,  8'd13,
        8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,  8'd16,
        8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,  8'd20,
        8'd21,  8'd21,  8'd22,  8'd22,  8'd23,  8'd24,  8'd24,  8'd25,
        8'd25,  8'd26,  8'd27,  8'd27,  8'd28,  8'd29,  8'd29,  8'd30,
        8'd31,  8'd32,  8'd32,  8'd33,  8'd34,  8'd35,  8'd35,  8'd36,
        8'd37,  8'd38,  8'd39,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,
        8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd49,  8'd50,  8'd50,
        8'd51,  8'd52,  8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,
        8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd66,  8'd67,  8'd68,
        8'd69,  8'd70,  8'd72,  8'd73,  8'd74,  8'd75,  8'd77,  8'd78,
        8'd79,  8'd81,  8'd82,  8'd83,  8'd85,  8'd86,  8'd87,  8'd89,
        8'd90,  8'd92,  8'd93,  8'd95,  8'd96,  8'd98,  8'd99,  8'd101,
        8'd102, 8'd104, 8'd105, 8'd107, 8'd109, 8'd110, 8'd112, 8'd114,
        8'd115, 8'd117, 8'd119, 8'd120, 8'd122, 8'd124, 8'd126, 8'd127,
        8'd129, 8'd131, 8'd133, 8'd135, 8'd137, 8'd138, 8'd140, 8'd142,
        8'd144, 8'd146, 8'd148, 8'd150, 8'd152, 8'd154, 8'd156, 8'd158,
        8'd160, 8'd162, 8'd164, 8'd167, 8'd169, 8'd171, 8'd173, 8'd175,
        8'd177, 8'd180, 8'd182, 8'd184, 8'd186, 8'd189, 8'd191, 8'd193,
        8'd196, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213,
        8'd215, 8'd218, 8'd220, 8'd223, 8'd225, 8'd228, 8'd231, 8'd233,
        8'd236, 8'd239, 8'd241, 8'd244, 8'd247, 8'd249, 8'd252, 8'd255
    };

endpackage

[rtl/core/pdsr_divider.sv]
module pdsr_divider (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start,
    input  logic [7:0] dividend,
    input  logic [8:0] divisor,
    output logic       done,
    output logic [7:0] quotient
);
    logic [7:0] rem_reg, rem_next;
    logic [7:0] quo_reg, quo_next;
    logic [8:0] dvs_reg, dvs_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [8:0] trial;
    logic [8:0] diff;
    logic       qbit;

    // one restoring step per cycle, quotient shifts in behind the dividend
    always_comb begin
        trial     = {rem_reg, quo_reg[7]};
        diff      = trial - dvs_reg;
        qbit      = (trial >= dvs_reg);
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = 8'd0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = 3'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = qbit ? diff[7:0] : trial[7:0];
            quo_next = {quo_reg[6:0], qbit};
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/core/pdsr_datapath.sv]
module pdsr_datapath #(
    parameter int unsigned WIDTH  = 16,
    parameter int unsigned HEIGHT = 9,
    parameter int unsigned DOTS   = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pdsr_pkg::pdsr_cmd_t   cmd,
    output pdsr_pkg::pdsr_status_t status,
    input  logic                  cfg_wr_en,
    input  logic [7:0]            cfg_wr_data,
    input  logic [39:0]           s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [15:0]           m_tdata,
    output logic                  m_tlast
);
    import pdsr_pkg::*;

    localparam int unsigned PH_DEPTH = (DOTS < 16) ? DOTS : 16;
    localparam int unsigned PH_AW    = (PH_DEPTH > 1) ? $clog2(PH_DEPTH) : 1;
    localparam logic [8:0]  W9       = 9'(WIDTH);
    localparam logic [8:0]  H9       = 9'(HEIGHT);
    localparam logic [4:0]  DOTS5    = 5'(PH_DEPTH);
    localparam logic [15:0] W16      = 16'(WIDTH);

    // input fields
    logic [3:0] in_idx;
    logic [7:0] in_x, in_y, in_peak, in_phase;
    assign in_idx   = s_tdata[3:0];
    assign in_x     = s_tdata[11:4];
    assign in_y     = s_tdata[19:12];
    assign in_peak  = s_tdata[27:20];
    assign in_phase = s_tdata[35:28];

    logic             unused_in;
    assign unused_in = ^{s_tdata[39:36], s_tuser};

    logic [7:0]       steps_reg;
    logic [7:0]       ph_store_reg [PH_DEPTH];
    logic [PH_AW-1:0] idx_reg;
    logic [7:0]       x_reg, y_reg, peak_reg, ph_reg;
    logic [7:0]       level_reg;
    logic [4:0]       mask_reg;
    logic [2:0]       slot_reg;
    logic             m_valid_reg;
    logic [15:0]      m_data_reg;
    logic             m_last_reg;

    // pulse_steps register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg <= 8'(STEPS_RST);
        end else if (cfg_wr_en) begin
            steps_reg <= cfg_wr_data;
        end
    end

    // rise / fall split and divisor
    logic [7:0] half;
    logic       falling;
    logic [7:0] fall_i;
    logic [8:0] divisor;
    logic       div_done;
    logic [7:0] quotient;
    logic [8:0] half9;
    assign half9   = ({1'b0, steps_reg} + 9'd1) >> 1;
    assign half    = half9[7:0];
    assign falling = (ph_reg >= half);
    assign fall_i  = ph_reg - half;
    assign divisor = {1'b0, falling ? fall_i : ph_reg} + 9'd1;

    pdsr_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (peak_reg),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // phase store, load and advance
    logic [7:0] load_val;
    logic [7:0] adv_inc;
    logic [7:0] adv_val;
    assign load_val = (in_phase >= steps_reg) ? 8'd0 : in_phase;
    assign adv_inc  = ph_reg + 8'd1;
    assign adv_val  = (adv_inc >= steps_reg) ? 8'd0 : adv_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < PH_DEPTH; k++) begin
                ph_store_reg[k] <= 8'd0;
            end
        end else if (cmd.load_phase) begin
            ph_store_reg[in_idx[PH_AW-1:0]] <= load_val;
        end else if (cmd.advance) begin
            ph_store_reg[idx_reg] <= adv_val;
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            idx_reg  <= in_idx[PH_AW-1:0];
            x_reg    <= in_x;
            y_reg    <= in_y;
            peak_reg <= in_peak;
            ph_reg   <= ph_store_reg[in_idx[PH_AW-1:0]];
        end
    end

    // level and on-display mask
    logic [7:0] level_calc;
    logic [4:0] mask_calc;
    logic [8:0] x9, y9;
    logic       x_in, y_in;
    assign x9 = {1'b0, x_reg};
    assign y9 = {1'b0, y_reg};
    assign x_in = (x9 < W9);
    assign y_in = (y9 < H9);

    always_comb begin
        if (!falling) begin
            level_calc = peak_reg - quotient;
        end else if (fall_i == 8'd0) begin
            level_calc = peak_reg;
        end else begin
            level_calc = quotient;
        end
        mask_calc[SLOT_CENTRE] = x_in && y_in;
        mask_calc[SLOT_DOWN]   = x_in && ((y9 + 9'd1) < H9);
        mask_calc[SLOT_UP]     = x_in && (y_reg != 8'd0) && ((y9 - 9'd1) < H9);
        mask_calc[SLOT_RIGHT]  = y_in && ((x9 + 9'd1) < W9);
        mask_calc[SLOT_LEFT]   = y_in && (x_reg != 8'd0) && ((x9 - 9'd1) < W9);
    end

    always_ff @(posedge aclk) begin
        if (cmd.level_ld) begin
            level_reg <= level_calc;
            mask_reg  <= mask_calc;
        end
    end

    // slot counter
    always_ff @(posedge aclk) begin
        if (cmd.level_ld) begin
            slot_reg <= SLOT_CENTRE;
        end else if (cmd.step) begin
            slot_reg <= slot_reg + 3'd1;
        end
    end

    // current write
    logic [7:0]  px, py;
    logic [15:0] addr_full;
    logic [7:0]  pix_level;
    logic [4:0]  rest;
    logic        pix_last;

    always_comb begin
        px = x_reg;
        py = y_reg;
        unique case (slot_reg)
            SLOT_CENTRE: begin
                px = x_reg;
                py = y_reg;
            end
            SLOT_DOWN:   py = y_reg + 8'd1;
            SLOT_UP:     py = y_reg - 8'd1;
            SLOT_RIGHT:  px = x_reg + 8'd1;
            SLOT_LEFT:   px = x_reg - 8'd1;
            default: begin
                px = x_reg;
                py = y_reg;
            end
        endcase
        addr_full = {8'd0, py} * W16 + {8'd0, px};
        pix_level = (slot_reg == SLOT_CENTRE) ? level_reg : {1'b0, level_reg[7:1]};
        rest      = mask_reg >> slot_reg;
        pix_last  = (rest[4:1] == 4'd0);
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= {GAMMA_LUT[pix_level], addr_full[7:0]};
            m_last_reg <= pix_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // status
    assign status.idx_ok    = ({1'b0, in_idx} < DOTS5);
    assign status.div_done  = div_done;
    assign status.pix_on    = mask_reg[slot_reg];
    assign status.slot_last = (slot_reg == SLOT_LEFT);
    assign status.out_free  = !m_valid_reg || m_tready;

endmodule

[rtl/core/pdsr_ctrl.sv]
module pdsr_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tuser,
    output logic                   s_tready,
    input  pdsr_pkg::pdsr_status_t status,
    output pdsr_pkg::pdsr_cmd_t    cmd
);
    import pdsr_pkg::*;

    pdsr_state_t state_reg, state_next;
    logic        accept;
    logic        slot_done;

    assign accept    = s_tvalid && (state_reg == ST_IDLE);
    assign slot_done = !status.pix_on || status.out_free;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && status.idx_ok && !s_tuser) begin
                    state_next = ST_START;
                end
            end
            ST_START: state_next = ST_DIV;
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_LEVEL;
                end
            end
            ST_LEVEL: state_next = ST_EMIT;
            ST_EMIT: begin
                if (slot_done && status.slot_last) begin
                    state_next = ST_ADV;
                end
            end
            ST_ADV: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready       = 1'b1;
                cmd.capture    = accept && status.idx_ok && !s_tuser;
                cmd.load_phase = accept && status.idx_ok && s_tuser;
            end
            ST_START: cmd.div_start = 1'b1;
            ST_DIV:   cmd.div_start = 1'b0;
            ST_LEVEL: cmd.level_ld = 1'b1;
            ST_EMIT: begin
                cmd.emit = status.pix_on && status.out_free;
                cmd.step = slot_done;
            end
            ST_ADV:   cmd.advance = 1'b1;
            default:  cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/pulse_dot_star_renderer.sv]
// Pulsing dot renderer for a small LED matrix framebuffer.
// Input stream (s_): one request per dot. tuser selects render (0) or load
// phase (1). A render request reads the dot's stored phase, forms a pulse
// level, and sends up to five framebuffer writes on the output stream (m_):
// the centre at full level, then below, above, right and left at half level,
// each gamma corrected; positions off the display are skipped, and tlast
// marks the final write. The phase then advances and wraps at pulse_steps.
// A load request stores a phase and sends nothing; a request
// with a dot index at or above DOTS is dropped.
// Flow: one request at a time. A render runs through capture, divider
// launch, the bit-serial 8-bit divider (eight steps and its done flag)
// that sets the pace, level, five write slots and the phase write-back.
// When the receiver stalls, the output register holds its write and the
// write loop waits; new requests are taken again once the phase is written.
// Reset clears all dot phases to zero, pulse_steps to 16 and the output.
// cfg_wr_en writes pulse_steps from cfg_wr_data; do so only while idle.
module pulse_dot_star_renderer #(
    parameter int unsigned WIDTH  = 16,
    parameter int unsigned HEIGHT = 9,
    parameter int unsigned DOTS   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,   // pulse_steps
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,       // dot_index, dot_x, dot_y, peak_brightness, phase
    input  logic        s_tuser,       // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // pixel_address, pixel_value
    output logic        m_tlast        // last
);
    import pdsr_pkg::*;

    pdsr_cmd_t    cmd;
    pdsr_status_t status;

    pdsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pdsr_datapath #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT),
        .DOTS   (DOTS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule
